/* rtl/bfnp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-point search package
// Constants, codes and control types shared by the nearest-point search block.
// ----------------------------------------------------------------------------
package bfnp_pkg;

    // Store size and field widths.
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 20;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MAG_W      = COORD_BITS;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int POINT_W    = 3 * COORD_BITS;
    localparam int STATUS_W   = 3;
    localparam int OP_W       = 2;

    // Operation codes. Any code with the high bit set is a query.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_CLEARED  = 3'd0,
        STAT_STORED   = 3'd1,
        STAT_DROPPED  = 3'd2,
        STAT_ANSWERED = 3'd3,
        STAT_EMPTY    = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // An input transfer completes this cycle.
        logic issue;    // Read the next store entry into the distance pipeline.
        logic finish;   // Write the query answer into the output register.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_empty;  // No point is stored.
        logic last_issue;   // The entry being read now is the last stored one.
        logic pipe_idle;    // No entry is in flight in the distance pipeline.
        logic out_free;     // The output register can take a result this cycle.
    } t_stat;

endpackage

/* rtl/bfnp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-point search channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------

// Input item channel: an operation and one point.
interface bfnp_in_if;
    import bfnp_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               operation;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic signed [COORD_BITS-1:0]  coord_z;

    modport source (output valid, operation, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, operation, coord_x, coord_y, coord_z, output ready);
endinterface

// Result item channel: status, index and squared distance.
interface bfnp_out_if;
    import bfnp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     point_index;
    logic [DIST_W-1:0]    best_distance_sq;

    modport source (output valid, status, point_index, best_distance_sq, input ready);
    modport sink   (input valid, status, point_index, best_distance_sq, output ready);
endinterface

/* rtl/brute_force_nearest_point.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brute-force nearest-point search
// Stores up to 1024 3D points and answers nearest-point queries by a full scan.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Payload
//   i_item     in         operation, coord_x, coord_y, coord_z
//   o_result   out        status, point_index, best_distance_sq
//
// Clear, load and a query on an empty store write their result to the output
// register at the input transfer.
// A query on N stored points reads one store entry per cycle, runs each
// through four pipeline stages for the distance, then writes the answer.
// Reset empties the store. While the output register holds a result that is
// not taken, no new item is accepted.
// ----------------------------------------------------------------------------
module brute_force_nearest_point (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfnp_in_if.sink    i_item,
    bfnp_out_if.source o_result
);
    import bfnp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Controller.
    bfnp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_query (i_item.operation[OP_W-1]),
        .i_stat     (stat),
        .o_in_ready (i_item.ready),
        .o_cmd      (cmd)
    );

    // Datapath.
    bfnp_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_operation        (i_item.operation),
        .i_coord_x          (i_item.coord_x),
        .i_coord_y          (i_item.coord_y),
        .i_coord_z          (i_item.coord_z),
        .i_out_ready        (o_result.ready),
        .o_stat             (stat),
        .o_out_valid        (o_result.valid),
        .o_status           (o_result.status),
        .o_point_index      (o_result.point_index),
        .o_best_distance_sq (o_result.best_distance_sq)
    );

endmodule

/* rtl/bfnp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-point search controller
// Sequences input transfers, the store scan of a query and the answer write.
// ----------------------------------------------------------------------------
module bfnp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_query,
    input  bfnp_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output bfnp_pkg::t_cmd  o_cmd
);
    import bfnp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                // Every item in this state gives its result at once, except a
                // query on a non-empty store, so the output register must be free.
                o_in_ready   = i_stat.out_free;
                o_cmd.accept = i_in_valid && i_stat.out_free;
                if (o_cmd.accept && i_in_query && !i_stat.count_empty) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // One store entry enters the distance pipeline each cycle.
                o_cmd.issue = 1'b1;
                if (i_stat.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Wait for the last entry to reach the best-so-far register and for the output register to be free.
                if (i_stat.pipe_idle && i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/bfnp_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-point search datapath
// Point store, point count, squared-distance pipeline, best-so-far tracking
// and the output register.
// ----------------------------------------------------------------------------
module bfnp_dpath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  bfnp_pkg::t_cmd                          i_cmd,
    input  logic [bfnp_pkg::OP_W-1:0]               i_operation,
    input  logic signed [bfnp_pkg::COORD_BITS-1:0]  i_coord_x,
    input  logic signed [bfnp_pkg::COORD_BITS-1:0]  i_coord_y,
    input  logic signed [bfnp_pkg::COORD_BITS-1:0]  i_coord_z,
    input  logic                                    i_out_ready,
    output bfnp_pkg::t_stat                         o_stat,
    output logic                                    o_out_valid,
    output logic [bfnp_pkg::STATUS_W-1:0]           o_status,
    output logic [bfnp_pkg::IDX_W-1:0]              o_point_index,
    output logic [bfnp_pkg::DIST_W-1:0]             o_best_distance_sq
);
    import bfnp_pkg::*;

    // Point store: x in the high third, then y, then z.
    logic [POINT_W-1:0] mem [MAX_POINTS];

    logic [CNT_W-1:0]             r_count;
    logic [IDX_W-1:0]             r_addr;
    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_qz;

    // Pipeline stage 1: read data.
    logic                         r_v1;
    logic [IDX_W-1:0]             r_tag1;
    logic [POINT_W-1:0]           r_rd_data;
    // Stage 2: magnitudes of the coordinate differences.
    logic                         r_v2;
    logic [IDX_W-1:0]             r_tag2;
    logic [MAG_W-1:0]             r_ax, r_ay, r_az;
    // Stage 3: squares.
    logic                         r_v3;
    logic [IDX_W-1:0]             r_tag3;
    logic [SQ_W-1:0]              r_sx, r_sy, r_sz;
    // Stage 4: sum.
    logic                         r_v4;
    logic [IDX_W-1:0]             r_tag4;
    logic [DIST_W-1:0]            r_sum;
    // Best so far.
    logic [IDX_W-1:0]             r_best_idx;
    logic [DIST_W-1:0]            r_best;

    // Output register.
    logic                         r_out_valid;
    logic [STATUS_W-1:0]          r_status;
    logic [IDX_W-1:0]             r_out_idx;
    logic [DIST_W-1:0]            r_out_dist;

    logic                         is_query;
    logic                         is_full;
    logic                         do_store;
    logic signed [DIFF_W-1:0]     dx, dy, dz;
    logic [DIFF_W-1:0]            mx, my, mz;

    assign is_query = i_operation[OP_W-1];
    assign is_full  = (r_count == CNT_W'(MAX_POINTS));
    assign do_store = i_cmd.accept && (i_operation == OP_LOAD) && !is_full;

    // Status toward the controller.
    assign o_stat.count_empty = (r_count == '0);
    assign o_stat.last_issue  = ({1'b0, r_addr} == (r_count - CNT_W'(1)));
    assign o_stat.pipe_idle   = !(r_v1 || r_v2 || r_v3 || r_v4);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // Point store write and scan read.
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            mem[r_count[IDX_W-1:0]] <= {i_coord_x, i_coord_y, i_coord_z};
        end
        if (i_cmd.issue) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // Point count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept && (i_operation == OP_CLEAR)) begin
            r_count <= '0;
        end else if (do_store) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Query latch and scan address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_query) begin
            r_qx   <= i_coord_x;
            r_qy   <= i_coord_y;
            r_qz   <= i_coord_z;
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + IDX_W'(1);
        end
    end

    // Coordinate differences, sign-extended by one bit so they cannot overflow.
    always_comb begin
        dx = DIFF_W'($signed(r_rd_data[POINT_W-1 -: COORD_BITS])) - DIFF_W'(r_qx);
        dy = DIFF_W'($signed(r_rd_data[2*COORD_BITS-1 -: COORD_BITS])) - DIFF_W'(r_qy);
        dz = DIFF_W'($signed(r_rd_data[COORD_BITS-1:0])) - DIFF_W'(r_qz);
        mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        mz = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Pipeline payload: magnitudes, squares, then the three-way sum.
    always_ff @(posedge i_clk) begin
        r_tag1 <= r_addr;
        r_tag2 <= r_tag1;
        r_tag3 <= r_tag2;
        r_tag4 <= r_tag3;
        r_ax   <= mx[MAG_W-1:0];
        r_ay   <= my[MAG_W-1:0];
        r_az   <= mz[MAG_W-1:0];
        r_sx   <= r_ax * r_ax;
        r_sy   <= r_ay * r_ay;
        r_sz   <= r_az * r_az;
        r_sum  <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
    end

    // Best so far: the first entry seeds it, later ones replace it only when
    // strictly closer, so ties stay with the lower index.
    always_ff @(posedge i_clk) begin
        if (r_v4 && ((r_tag4 == '0) || (r_sum < r_best))) begin
            r_best     <= r_sum;
            r_best_idx <= r_tag4;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish || (i_cmd.accept && !(is_query && !o_stat.count_empty))) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status   <= STAT_ANSWERED;
            r_out_idx  <= r_best_idx;
            r_out_dist <= r_best;
        end else if (i_cmd.accept) begin
            r_out_idx  <= '0;
            r_out_dist <= '0;
            if (is_query) begin
                r_status <= STAT_EMPTY;
            end else if (i_operation == OP_CLEAR) begin
                r_status <= STAT_CLEARED;
            end else if (is_full) begin
                r_status <= STAT_DROPPED;
            end else begin
                r_status  <= STAT_STORED;
                r_out_idx <= r_count[IDX_W-1:0];
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_point_index      = r_out_idx;
    assign o_best_distance_sq = r_out_dist;

endmodule

/* tb/nearest_point_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-point search result checker
// Watches the item and result channels of the search block. It keeps its own
// copy of the point store, works out the result of every accepted item and
// compares each accepted result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module nearest_point_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bfnp_in_if   i_item,
    bfnp_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending
);
    import bfnp_pkg::*;

    // One result as the block should deliver it.
    typedef struct {
        t_status            status;
        logic [IDX_W-1:0]   point_index;
        logic [DIST_W-1:0]  distance_sq;
    } t_answer;

    // Shadow copy of the point store and its fill level.
    logic signed [COORD_BITS-1:0] store_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] store_y [MAX_POINTS];
    logic signed [COORD_BITS-1:0] store_z [MAX_POINTS];
    int unsigned stored_count = 0;

    t_answer pending_answers [$];
    t_answer oldest;
    int      fail_count = 0;

    // Apply one item to the shadow store and queue the result it must produce.
    task automatic predict_nearest(
        input logic [OP_W-1:0]              op,
        input logic signed [COORD_BITS-1:0] qx,
        input logic signed [COORD_BITS-1:0] qy,
        input logic signed [COORD_BITS-1:0] qz
    );
        t_answer     ans;
        longint      dx;
        longint      dy;
        longint      dz;
        logic [63:0] sq_sum;
        logic [63:0] best;
        int unsigned best_idx;
        ans.status      = STAT_CLEARED;
        ans.point_index = '0;
        ans.distance_sq = '0;
        best            = '0;
        best_idx        = 0;
        if (op == OP_CLEAR) begin
            stored_count = 0;
        end else if (op == OP_LOAD) begin
            if (stored_count < MAX_POINTS) begin
                store_x[stored_count] = qx;
                store_y[stored_count] = qy;
                store_z[stored_count] = qz;
                ans.status      = STAT_STORED;
                ans.point_index = IDX_W'(stored_count);
                stored_count++;
            end else begin
                ans.status = STAT_DROPPED;
            end
        end else if (stored_count == 0) begin
            // Any code with the high bit set is a query.
            ans.status = STAT_EMPTY;
        end else begin
            // Full scan; only a strictly smaller distance replaces the best,
            // so the lowest index wins a tie.
            for (int unsigned i = 0; i < stored_count; i++) begin
                dx     = longint'(store_x[i]) - longint'(qx);
                dy     = longint'(store_y[i]) - longint'(qy);
                dz     = longint'(store_z[i]) - longint'(qz);
                sq_sum = dx * dx + dy * dy + dz * dz;
                if (i == 0 || sq_sum < best) begin
                    best     = sq_sum;
                    best_idx = i;
                end
            end
            ans.status      = STAT_ANSWERED;
            ans.point_index = IDX_W'(best_idx);
            ans.distance_sq = DIST_W'(best);
        end
        pending_answers = {pending_answers, ans};
    endtask

    // Count a failure; only the first few are described.
    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // Results are checked before the item of the same edge is predicted, so a
    // spurious result can never be matched with a fresh prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_count = 0;
            pending_answers.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (pending_answers.size() == 0) begin
                    note_failure($sformatf(
                        "result with none expected: status %0d index %0d dist %0d",
                        i_result.status, i_result.point_index, i_result.best_distance_sq));
                end else begin
                    oldest = pending_answers.pop_front();
                    if (i_result.status !== oldest.status ||
                        i_result.point_index !== oldest.point_index ||
                        i_result.best_distance_sq !== oldest.distance_sq) begin
                        note_failure($sformatf(
                            "expected status %0d index %0d dist %0d, got %0d %0d %0d",
                            oldest.status, oldest.point_index, oldest.distance_sq,
                            i_result.status, i_result.point_index,
                            i_result.best_distance_sq));
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                predict_nearest(i_item.operation, i_item.coord_x, i_item.coord_y,
                                i_item.coord_z);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_answers.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-point search testbench
// Drives items into the search block: a directed run over the extreme
// coordinates, ties and empty and cleared stores, then random sets of points
// with queries aimed at and around them. Both channels stall at random. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import bfnp_pkg::*;

    localparam int QUIET_LIMIT    = 5000;
    localparam int TOTAL_ITEMS    = 580;
    localparam int TAIL_ITEMS     = 3;
    localparam int STEADY_FROM    = 250;
    localparam int STEADY_TO      = 350;
    localparam int IDLE_PERCENT   = 29;
    localparam int COORD_HI       = 2 ** (COORD_BITS - 1) - 1;
    localparam int COORD_LO       = -(2 ** (COORD_BITS - 1));

    // The spare operation code decodes as a query.
    localparam logic [OP_W-1:0] OP_QUERY_ALT = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    localparam t_coord XYZ_MAX = t_coord'(COORD_HI);
    localparam t_coord XYZ_MIN = t_coord'(COORD_LO);

    logic   clk    = 1'b0;
    logic   rst_n  = 1'b0;
    logic   steady = 1'b0;
    int     items_sent = 0;
    int     quiet_cycles = 0;
    int     fail_count;
    int     pending;
    t_point set_points [$];

    bfnp_in_if  item_if ();
    bfnp_out_if result_if ();

    brute_force_nearest_point dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    nearest_point_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_if),
        .i_result     (result_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 100 MHz clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure, off during the steady stretch.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            result_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: a run with no transfer for too long is a hang.
    always @(posedge clk) begin
        if (!rst_n || (item_if.valid && item_if.ready) ||
            (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic t_coord clamp_coord(input int v);
        if (v > COORD_HI) begin
            return XYZ_MAX;
        end
        if (v < COORD_LO) begin
            return XYZ_MIN;
        end
        return t_coord'(v);
    endfunction

    // Mix of small values, the two extremes and the full range.
    function automatic t_coord random_coord();
        case ($urandom_range(3))
            0: return clamp_coord(int'($urandom_range(32)) - 16);
            1: return ($urandom_range(1) != 0) ? XYZ_MAX : XYZ_MIN;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_coord nudge(input t_coord c);
        return clamp_coord(int'(c) + int'($urandom_range(6)) - 3);
    endfunction

    // One input transfer, with random idle cycles ahead of it. Called and
    // returning at a falling edge. The points of the current set are tracked
    // so that queries can be aimed at them.
    task automatic send_item(input logic [OP_W-1:0] op, input t_coord x, input t_coord y,
                             input t_coord z);
        t_point p;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.operation <= op;
        item_if.coord_x   <= x;
        item_if.coord_y   <= y;
        item_if.coord_z   <= z;
        @(posedge clk);
        while (!item_if.ready) begin
            @(posedge clk);
        end
        items_sent++;
        steady = (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
        p = '{x: x, y: y, z: z};
        if (op == OP_CLEAR) begin
            set_points.delete();
        end else if (op == OP_LOAD && set_points.size() < MAX_POINTS) begin
            set_points = {set_points, p};
        end
        @(negedge clk);
    endtask

    // Load a fresh point, or now and then a copy of the last one to make ties.
    task automatic load_random_point();
        t_point p;
        if (set_points.size() != 0 && $urandom_range(4) == 0) begin
            p = set_points[set_points.size() - 1];
            send_item(OP_LOAD, p.x, p.y, p.z);
        end else begin
            send_item(OP_LOAD, random_coord(), random_coord(), random_coord());
        end
    endtask

    // Query on a stored point, close to one, or anywhere.
    task automatic query_near_set(input bit exact);
        t_point           p;
        logic [OP_W-1:0]  op;
        op = ($urandom_range(9) == 0) ? OP_QUERY_ALT : OP_QUERY;
        if (set_points.size() == 0 || $urandom_range(5) == 0) begin
            send_item(op, random_coord(), random_coord(), random_coord());
        end else begin
            p = set_points[$urandom_range(set_points.size() - 1)];
            if (exact) begin
                send_item(op, p.x, p.y, p.z);
            end else begin
                send_item(op, nudge(p.x), nudge(p.y), nudge(p.z));
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        logic [OP_W-1:0] noise_op;
        item_if.valid     = 1'b0;
        item_if.operation = OP_CLEAR;
        item_if.coord_x   = '0;
        item_if.coord_y   = '0;
        item_if.coord_z   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty store, extremes, largest distance, ties, clears.
        send_item(OP_QUERY, '0, '0, '0);
        send_item(OP_LOAD, XYZ_MIN, XYZ_MIN, XYZ_MIN);
        send_item(OP_LOAD, XYZ_MAX, XYZ_MAX, XYZ_MAX);
        send_item(OP_QUERY, XYZ_MAX, XYZ_MAX, XYZ_MAX);
        send_item(OP_QUERY, XYZ_MIN, XYZ_MIN, XYZ_MIN);
        send_item(OP_CLEAR, XYZ_MAX, XYZ_MIN, XYZ_MAX);
        send_item(OP_LOAD, XYZ_MIN, XYZ_MIN, XYZ_MIN);
        send_item(OP_QUERY, XYZ_MAX, XYZ_MAX, XYZ_MAX);
        send_item(OP_LOAD, '0, '0, '0);
        send_item(OP_LOAD, '0, '0, '0);
        send_item(OP_QUERY_ALT, t_coord'(1), t_coord'(1), t_coord'(1));
        send_item(OP_LOAD, t_coord'(2), '0, '0);
        send_item(OP_QUERY, t_coord'(1), '0, '0);
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_QUERY, XYZ_MIN, XYZ_MAX, XYZ_MIN);
        send_item(OP_LOAD, t_coord'(5), t_coord'(-7), t_coord'(9));
        send_item(OP_LOAD, t_coord'(-5), t_coord'(7), t_coord'(-9));
        send_item(OP_QUERY_ALT, '0, '0, '0);
        send_item(OP_QUERY, t_coord'(-4), t_coord'(6), t_coord'(-8));
        send_item(OP_LOAD, XYZ_MIN, XYZ_MAX, XYZ_MIN);
        send_item(OP_QUERY, XYZ_MAX, XYZ_MIN, XYZ_MAX);
        send_item(OP_CLEAR, '0, '0, '0);

        // Random: mostly clear, load a small set, then query around it.
        while (items_sent < TOTAL_ITEMS - TAIL_ITEMS) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    noise_op = OP_W'($urandom_range(3));
                    send_item(noise_op, random_coord(), random_coord(), random_coord());
                end
            end else begin
                if ($urandom_range(4) != 0) begin
                    send_item(OP_CLEAR, random_coord(), random_coord(), random_coord());
                end
                repeat (($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12)) begin
                    load_random_point();
                end
                repeat ($urandom_range(1, 6)) begin
                    query_near_set($urandom_range(2) == 0);
                end
            end
        end

        // Close with the spare query code, a clear and a query on the empty store.
        send_item(OP_QUERY_ALT, random_coord(), random_coord(), random_coord());
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_QUERY, random_coord(), random_coord(), random_coord());
        item_if.valid <= 1'b0;

        // Drain the outstanding results.
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
